@@ design/sync_frame_parser_fletcher_core_assert.svh @@
// Assertion macros shared by the frame parser RTL.
// No dependencies; define NO_ASSERTIONS to compile them away.
`ifndef SYNC_FRAME_PARSER_FLETCHER_CORE_ASSERT_SVH
`define SYNC_FRAME_PARSER_FLETCHER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define SFP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sfp assertion failed");

// Next-cycle implication, disabled during reset.
`define SFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sfp assertion failed");

`else

`define SFP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ design/sfp_pkg.sv @@
// Shared types and constants for the sync frame parser.
// No dependencies.
`default_nettype none

package sfp_pkg;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h62;
    localparam logic [7:0] MAX_PAYLOAD_RST = 8'd255;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'd0,
        PH_SYNC1 = 4'd1,
        PH_SYNC2 = 4'd2,
        PH_CLASS = 4'd3,
        PH_ID    = 4'd4,
        PH_LEN1  = 4'd5,
        PH_DATA  = 4'd6,
        PH_SUMA  = 4'd7,
        PH_SUMB  = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_SYNC2    = 3'd1,
        ERR_BUSY     = 3'd2,
        ERR_TOO_LONG = 3'd3,
        ERR_SUM_A    = 3'd4,
        ERR_SUM_B    = 3'd5
    } err_kind_t;

    typedef enum logic [1:0] {
        CFG_SYNC_FIRST  = 2'd0,
        CFG_SYNC_SECOND = 2'd1,
        CFG_MAX_PAYLOAD = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       frame_ok;
        logic       frame_error;
        err_kind_t  error_kind;
        logic [7:0] frame_class;
        logic [7:0] frame_id;
        logic [7:0] frame_length;
        logic [7:0] error_total;
    } result_t;

endpackage

`default_nettype wire

@@ design/sfp_in_if.sv @@
// Input channel: one received byte plus the consumer busy flag per request.
// No dependencies.
`default_nettype none

interface sfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       consumer_busy;

    modport source (output valid, output rx_byte, output consumer_busy, input ready);
    modport sink   (input valid, input rx_byte, input consumer_busy, output ready);
endinterface

`default_nettype wire

@@ design/sfp_out_if.sv @@
// Output channel: one parse result per request.
// No dependencies.
`default_nettype none

interface sfp_out_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_ok;
    logic       frame_error;
    logic [2:0] error_kind;
    logic [7:0] frame_class;
    logic [7:0] frame_id;
    logic [7:0] frame_length;
    logic [7:0] error_total;

    modport source (
        output valid, output payload_valid, output payload_byte, output payload_index,
        output frame_ok, output frame_error, output error_kind, output frame_class,
        output frame_id, output frame_length, output error_total, input ready
    );
    modport sink (
        input valid, input payload_valid, input payload_byte, input payload_index,
        input frame_ok, input frame_error, input error_kind, input frame_class,
        input frame_id, input frame_length, input error_total, output ready
    );
endinterface

`default_nettype wire

@@ design/sfp_cfg.sv @@
// Configuration register bank: sync bytes and payload limit.
// Depends on sfp_pkg.
`default_nettype none

module sfp_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [7:0]    cfg_wdata,
    output sfp_pkg::cfg_t      cfg
);

    sfp_pkg::cfg_t cfg_reg;
    sfp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (sfp_pkg::cfg_idx_t'(cfg_index))
                sfp_pkg::CFG_SYNC_FIRST:  cfg_next.sync_first  = cfg_wdata;
                sfp_pkg::CFG_SYNC_SECOND: cfg_next.sync_second = cfg_wdata;
                sfp_pkg::CFG_MAX_PAYLOAD: cfg_next.max_payload = cfg_wdata;
                default:                  cfg_next = cfg_reg;   // unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first  <= sfp_pkg::SYNC_FIRST_RST;
            cfg_reg.sync_second <= sfp_pkg::SYNC_SECOND_RST;
            cfg_reg.max_payload <= sfp_pkg::MAX_PAYLOAD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ design/sfp_parser.sv @@
// Parse state machine with Fletcher-8 sums; computes one result per byte.
// Depends on sfp_pkg and the assertion macro header.
`default_nettype none
`include "sync_frame_parser_fletcher_core_assert.svh"

module sfp_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          take,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          consumer_busy,
    input  wire sfp_pkg::cfg_t cfg,
    output sfp_pkg::result_t   res
);

    sfp_pkg::phase_t    phase_reg, phase_next;
    logic [7:0]         suma_reg, suma_next;
    logic [7:0]         sumb_reg, sumb_next;
    logic [7:0]         len_reg, len_next;      // low length byte; high byte is 0 when used
    logic [7:0]         pos_reg, pos_next;
    logic [7:0]         class_reg, class_next;
    logic [7:0]         id_reg, id_next;
    logic [7:0]         cnt_reg, cnt_next;

    logic [7:0]         suma_add;
    logic [7:0]         sumb_add;
    logic [7:0]         pos_inc;
    sfp_pkg::err_kind_t err;
    logic               pv;
    logic [7:0]         pb;
    logic [7:0]         pi;
    logic               ok;

    assign suma_add = suma_reg + rx_byte;
    assign sumb_add = sumb_reg + suma_add;
    assign pos_inc  = pos_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        suma_next  = suma_reg;
        sumb_next  = sumb_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        class_next = class_reg;
        id_next    = id_reg;
        cnt_next   = cnt_reg;
        err        = sfp_pkg::ERR_NONE;
        pv         = 1'b0;
        pb         = 8'd0;
        pi         = 8'd0;
        ok         = 1'b0;

        unique case (phase_reg)
            sfp_pkg::PH_HUNT:
            begin
                if (rx_byte == cfg.sync_first)
                    phase_next = sfp_pkg::PH_SYNC1;
            end
            sfp_pkg::PH_SYNC1:
            begin
                if (rx_byte != cfg.sync_second)
                    err = sfp_pkg::ERR_SYNC2;
                else
                begin
                    suma_next  = 8'd0;
                    sumb_next  = 8'd0;
                    phase_next = sfp_pkg::PH_SYNC2;
                end
            end
            sfp_pkg::PH_SYNC2:
            begin
                if (consumer_busy)
                    err = sfp_pkg::ERR_BUSY;
                else
                begin
                    suma_next  = suma_add;
                    sumb_next  = sumb_add;
                    class_next = rx_byte;
                    phase_next = sfp_pkg::PH_CLASS;
                end
            end
            sfp_pkg::PH_CLASS:
            begin
                suma_next  = suma_add;
                sumb_next  = sumb_add;
                id_next    = rx_byte;
                phase_next = sfp_pkg::PH_ID;
            end
            sfp_pkg::PH_ID:
            begin
                suma_next  = suma_add;
                sumb_next  = sumb_add;
                len_next   = rx_byte;
                phase_next = sfp_pkg::PH_LEN1;
            end
            sfp_pkg::PH_LEN1:
            begin
                suma_next = suma_add;
                sumb_next = sumb_add;
                // 16-bit length over limit: any high bit set, or low byte too big
                if (rx_byte != 8'd0 || len_reg > cfg.max_payload)
                    err = sfp_pkg::ERR_TOO_LONG;
                else
                begin
                    pos_next   = 8'd0;
                    phase_next = (len_reg == 8'd0) ? sfp_pkg::PH_SUMA : sfp_pkg::PH_DATA;
                end
            end
            sfp_pkg::PH_DATA:
            begin
                suma_next = suma_add;
                sumb_next = sumb_add;
                pv        = 1'b1;
                pb        = rx_byte;
                pi        = pos_reg;
                pos_next  = pos_inc;
                if (pos_inc >= len_reg || pos_inc == 8'd0)
                    phase_next = sfp_pkg::PH_SUMA;
            end
            sfp_pkg::PH_SUMA:
            begin
                if (rx_byte != suma_reg)
                    err = sfp_pkg::ERR_SUM_A;
                else
                    phase_next = sfp_pkg::PH_SUMB;
            end
            sfp_pkg::PH_SUMB:
            begin
                if (rx_byte != sumb_reg)
                    err = sfp_pkg::ERR_SUM_B;
                else
                begin
                    ok         = 1'b1;
                    phase_next = sfp_pkg::PH_HUNT;
                end
            end
            default:
            begin
                phase_next = sfp_pkg::PH_HUNT;
            end
        endcase

        if (err != sfp_pkg::ERR_NONE)
        begin
            cnt_next   = cnt_reg + 8'd1;
            phase_next = sfp_pkg::PH_HUNT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sfp_pkg::PH_HUNT;
            suma_reg  <= 8'd0;
            sumb_reg  <= 8'd0;
            len_reg   <= 8'd0;
            pos_reg   <= 8'd0;
            class_reg <= 8'd0;
            id_reg    <= 8'd0;
            cnt_reg   <= 8'd0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            suma_reg  <= suma_next;
            sumb_reg  <= sumb_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            class_reg <= class_next;
            id_reg    <= id_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        res.payload_valid = pv;
        res.payload_byte  = pb;
        res.payload_index = pi;
        res.frame_ok      = ok;
        res.frame_error   = (err != sfp_pkg::ERR_NONE);
        res.error_kind    = err;
        res.frame_class   = class_next;
        res.frame_id      = id_next;
        res.frame_length  = len_next;
        res.error_total   = cnt_next;
    end

    `SFP_ASSERT_NEXT(a_err_counts, clk, rst_n, take && res.frame_error, cnt_reg == $past(cnt_reg) + 8'd1)
    `SFP_ASSERT_NEXT(a_err_hunts, clk, rst_n, take && res.frame_error, phase_reg == sfp_pkg::PH_HUNT)
    `SFP_ASSERT_IMP(a_ok_no_err, clk, rst_n, res.frame_ok, !res.frame_error && phase_reg == sfp_pkg::PH_SUMB)
    `SFP_ASSERT_IMP(a_payload_in_data, clk, rst_n, res.payload_valid, phase_reg == sfp_pkg::PH_DATA)

endmodule

`default_nettype wire

@@ design/sfp_out_reg.sv @@
// Result register between the parser and the output channel.
// Depends on sfp_pkg.
`default_nettype none

module sfp_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire sfp_pkg::result_t d,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output sfp_pkg::result_t      q,
    output logic                  can_load
);

    logic             valid_reg, valid_next;
    sfp_pkg::result_t data_reg;

    // Slot frees up in the same cycle the sink takes the held result.
    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= d;
    end

    assign out_valid = valid_reg;
    assign q         = data_reg;

endmodule

`default_nettype wire

@@ design/sync_frame_parser_fletcher_core.sv @@
// Top level of the sync frame parser with Fletcher-8 check.
// Depends on sfp_pkg, sfp_in_if, sfp_out_if, sfp_cfg, sfp_parser, sfp_out_reg.
//
//  channel   dir  handshake     payload
//  in_ch     in   valid/ready   rx_byte[7:0], consumer_busy
//  out_ch    out  valid/ready   payload_valid/byte/index, frame_ok, frame_error,
//                               error_kind[2:0], frame_class, frame_id,
//                               frame_length, error_total
//  cfg       in   cfg_we        cfg_index[1:0], cfg_wdata[7:0]
//
// The parse step is a single state update feeding the result register, so a byte
// can be taken every clock while the result slot is free or being emptied.
// out_ch.valid rises in the cycle after input acceptance.
// in_ch.ready drops only when the result register is full and out_ch.ready
// is low; a stalled output holds its request unchanged.
// rst_n clears the parser state, the error count and the config registers
// (sync 0xB5/0x62, max payload 255). No clearing pass is needed.
`default_nettype none

module sync_frame_parser_fletcher_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    sfp_in_if.sink          in_ch,
    sfp_out_if.source       out_ch,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_wdata
);

    sfp_pkg::cfg_t    cfg;
    sfp_pkg::result_t step_res;
    sfp_pkg::result_t held_res;
    logic             take;
    logic             can_load;

    // A byte is taken whenever the result slot is free or being emptied.
    assign in_ch.ready = can_load;
    assign take        = in_ch.valid && can_load;

    sfp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sfp_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .rx_byte       (in_ch.rx_byte),
        .consumer_busy (in_ch.consumer_busy),
        .cfg           (cfg),
        .res           (step_res)
    );

    sfp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .d         (step_res),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .q         (held_res),
        .can_load  (can_load)
    );

    assign out_ch.payload_valid = held_res.payload_valid;
    assign out_ch.payload_byte  = held_res.payload_byte;
    assign out_ch.payload_index = held_res.payload_index;
    assign out_ch.frame_ok      = held_res.frame_ok;
    assign out_ch.frame_error   = held_res.frame_error;
    assign out_ch.error_kind    = held_res.error_kind;
    assign out_ch.frame_class   = held_res.frame_class;
    assign out_ch.frame_id      = held_res.frame_id;
    assign out_ch.frame_length  = held_res.frame_length;
    assign out_ch.error_total   = held_res.error_total;

endmodule

`default_nettype wire
